@@ src/fpc_pkg.sv @@
package fpc_pkg;

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);
  localparam int NUM_CAND  = 6;
  localparam int DIV_STAGES = 4;
  localparam int PIPE_DEPTH = DIV_STAGES + 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_PEAK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_WIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_PEAK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_WIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_PEAK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RED_WIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_PEAK   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_WIN    = 3'd7;

  // stage codes
  localparam logic [2:0] STG_NONE   = 3'd0;
  localparam logic [2:0] STG_CYAN   = 3'd1;
  localparam logic [2:0] STG_GREEN  = 3'd2;
  localparam logic [2:0] STG_BLUE   = 3'd3;
  localparam logic [2:0] STG_RED    = 3'd4;
  localparam logic [2:0] STG_GRAY   = 3'd5;
  localparam logic [2:0] STG_ALL    = 3'd6;
  localparam logic [2:0] STG_MASKED = 3'd7;

  typedef struct packed {
    logic [7:0] blue_value;
    logic [7:0] green_value;
    logic [7:0] red_value;
    logic [7:0] gray_value;
    logic       outside_mask;
  } fpc_in_t;

  typedef struct packed {
    logic       non_field;
    logic [2:0] stage_reached;
    logic [7:0] feature_value;
    logic [7:0] reliability;
  } fpc_out_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [7:0]  den;
    logic [7:0]  quo;
  } fpc_div_t;

  typedef struct packed {
    logic                       masked;
    logic                       non_field;
    logic [2:0]                 stage;
    logic [7:0]                 b;
    logic [7:0]                 g;
    logic [7:0]                 r;
    logic [7:0]                 y;
    fpc_div_t [NUM_CAND-1:0]    div;
  } fpc_work_t;

  function automatic logic [7:0] fpc_sat_sum(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic fpc_within(logic [7:0] v, logic [7:0] peak, logic [7:0] win);
    logic [7:0] d;
    d = (v >= peak) ? v - peak : peak - v;
    return d <= win;
  endfunction

  // Sets up num/den for the two-sided scale; fixed results go out as num / 1.
  function automatic fpc_div_t fpc_prep(logic [7:0] v, logic [7:0] t);
    logic [15:0] d16;
    fpc_div_t    p;
    d16   = '0;
    p.quo = '0;
    p.den = 8'd1;
    p.rem = '0;
    if (v < t) begin
      if (v != 8'd0) begin
        d16   = {8'd0, t - v};
        p.rem = (d16 << 8) - d16;
        p.den = t;
      end
    end else if (v == 8'hFF) begin
      p.rem = 16'd255;
    end else if (v > t) begin
      d16   = {8'd0, v - t};
      p.rem = (d16 << 8) - d16;
      p.den = 8'hFF - t;
    end else begin
      // equal: v / t is 1 for t >= 128, else v / (255 - t) is 0
      p.rem = {15'd0, t[7]};
    end
    return p;
  endfunction

  // one restoring step; quotient always fits 8 bits
  function automatic fpc_div_t fpc_div_step(fpc_div_t x, logic [2:0] pos);
    logic [15:0] sh;
    fpc_div_t    o;
    o  = x;
    sh = {8'd0, x.den} << pos;
    if (x.rem >= sh) begin
      o.rem      = x.rem - sh;
      o.quo[pos] = 1'b1;
    end
    return o;
  endfunction

endpackage

@@ src/field_pixel_classifier.sv @@
// Pixel field classifier.
// Input channel in_valid/in_ready/in_data carries one pixel beat (blue, green,
// red, gray, mask bit). Output channel out_valid/out_ready/out_data carries one
// result beat per pixel: non-field flag, deepest test stage, feature value and
// reliability. Results come out in input order.
// Config: cfg_we/cfg_index/cfg_wdata write the peak and window registers, one
// per cycle; write only while no pixel is in flight.
// Throughput: one pixel per clock while the output is not stalled. The six
// reliability divides run in parallel through four divider stages of two
// quotient bits each; prep and min-select take one stage each.
// Reset (synchronous, rst_n low) clears config registers and all valid bits.
// Stall: each stage holds while the one after it is full and stalled, so a
// bubble anywhere is squeezed out and in_ready drops only when all six
// stages hold beats.
module field_pixel_classifier (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fpc_pkg::fpc_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fpc_pkg::fpc_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [fpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                         cfg_wdata
);

  logic [7:0] cfg_r [fpc_pkg::NUM_REGS];

  logic [fpc_pkg::PIPE_DEPTH-1:0] vld_r;
  logic [fpc_pkg::PIPE_DEPTH-1:0] adv;
  fpc_pkg::fpc_work_t in_work;
  fpc_pkg::fpc_work_t work_r  [fpc_pkg::DIV_STAGES+1];
  fpc_pkg::fpc_work_t work_nxt[fpc_pkg::DIV_STAGES+1];
  fpc_pkg::fpc_out_t  out_r, out_nxt;

  logic [7:0] thr_g, thr_b, thr_r, thr_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fpc_pkg::NUM_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  assign thr_g = fpc_pkg::fpc_sat_sum(cfg_r[fpc_pkg::REG_GREEN_PEAK],
                                      cfg_r[fpc_pkg::REG_GREEN_WIN]);
  assign thr_b = fpc_pkg::fpc_sat_sum(cfg_r[fpc_pkg::REG_BLUE_PEAK],
                                      cfg_r[fpc_pkg::REG_BLUE_WIN]);
  assign thr_r = fpc_pkg::fpc_sat_sum(cfg_r[fpc_pkg::REG_RED_PEAK],
                                      cfg_r[fpc_pkg::REG_RED_WIN]);
  assign thr_y = fpc_pkg::fpc_sat_sum(cfg_r[fpc_pkg::REG_GRAY_PEAK],
                                      cfg_r[fpc_pkg::REG_GRAY_WIN]);

  // a stage moves when it is empty or the next one moves
  always_comb begin
    adv[fpc_pkg::PIPE_DEPTH-1] = !vld_r[fpc_pkg::PIPE_DEPTH-1] || out_ready;
    for (int k = fpc_pkg::PIPE_DEPTH-2; k >= 0; k--) adv[k] = !vld_r[k] || adv[k+1];
  end

  assign in_ready = adv[0];

  // stage 0: tests and divider setup
  always_comb begin
    logic [7:0] b, g, r, y;
    fpc_pkg::fpc_work_t w;
    b = in_data.blue_value;
    g = in_data.green_value;
    r = in_data.red_value;
    y = in_data.gray_value;
    w.masked    = in_data.outside_mask;
    w.b = b; w.g = g; w.r = r; w.y = y;
    w.non_field = 1'b1;
    w.stage     = fpc_pkg::STG_NONE;
    if (r < g) begin
      w.stage = fpc_pkg::STG_CYAN;
      if (b < g) begin
        w.stage = fpc_pkg::STG_GREEN;
        if (fpc_pkg::fpc_within(g, cfg_r[fpc_pkg::REG_GREEN_PEAK],
                                cfg_r[fpc_pkg::REG_GREEN_WIN])) begin
          w.stage = fpc_pkg::STG_BLUE;
          if (fpc_pkg::fpc_within(b, cfg_r[fpc_pkg::REG_BLUE_PEAK],
                                  cfg_r[fpc_pkg::REG_BLUE_WIN])) begin
            w.stage = fpc_pkg::STG_RED;
            if (fpc_pkg::fpc_within(r, cfg_r[fpc_pkg::REG_RED_PEAK],
                                    cfg_r[fpc_pkg::REG_RED_WIN])) begin
              w.stage = fpc_pkg::STG_GRAY;
              if (fpc_pkg::fpc_within(y, cfg_r[fpc_pkg::REG_GRAY_PEAK],
                                      cfg_r[fpc_pkg::REG_GRAY_WIN])) begin
                w.stage     = fpc_pkg::STG_ALL;
                w.non_field = 1'b0;
              end
            end
          end
        end
      end
    end
    w.div[0] = fpc_pkg::fpc_prep(r, g);
    w.div[1] = fpc_pkg::fpc_prep(b, g);
    w.div[2] = fpc_pkg::fpc_prep(g, thr_g);
    w.div[3] = fpc_pkg::fpc_prep(b, thr_b);
    w.div[4] = fpc_pkg::fpc_prep(r, thr_r);
    w.div[5] = fpc_pkg::fpc_prep(y, thr_y);
    in_work = w;
  end

  // divider stages: two quotient bits each, MSB first
  always_comb begin
    work_nxt[0] = in_work;
    for (int k = 1; k <= fpc_pkg::DIV_STAGES; k++) begin
      work_nxt[k] = work_r[k-1];
      for (int c = 0; c < fpc_pkg::NUM_CAND; c++) begin
        work_nxt[k].div[c] = fpc_pkg::fpc_div_step(work_nxt[k].div[c], 3'(9 - 2*k));
        work_nxt[k].div[c] = fpc_pkg::fpc_div_step(work_nxt[k].div[c], 3'(8 - 2*k));
      end
    end
  end

  // least reliability over the stages entered; ties keep the earlier one
  always_comb begin
    fpc_pkg::fpc_work_t w;
    logic [7:0] feat [fpc_pkg::NUM_CAND];
    logic [7:0] rel, fv;
    w = work_r[fpc_pkg::DIV_STAGES];
    feat[0] = w.r; feat[1] = w.b; feat[2] = w.g;
    feat[3] = w.b; feat[4] = w.r; feat[5] = w.y;
    rel = w.div[0].quo;
    fv  = feat[0];
    for (int c = 1; c < fpc_pkg::NUM_CAND; c++) begin
      if (3'(c) <= w.stage && rel > w.div[c].quo) begin
        rel = w.div[c].quo;
        fv  = feat[c];
      end
    end
    if (w.masked) begin
      out_nxt.non_field     = 1'b0;
      out_nxt.stage_reached = fpc_pkg::STG_MASKED;
      out_nxt.feature_value = '0;
      out_nxt.reliability   = '0;
    end else begin
      out_nxt.non_field     = w.non_field;
      out_nxt.stage_reached = w.stage;
      out_nxt.feature_value = fv;
      out_nxt.reliability   = rel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < fpc_pkg::PIPE_DEPTH; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= fpc_pkg::DIV_STAGES; k++) begin
      if (adv[k]) work_r[k] <= work_nxt[k];
    end
    if (adv[fpc_pkg::PIPE_DEPTH-1]) out_r <= out_nxt;
  end

  assign out_valid = vld_r[fpc_pkg::PIPE_DEPTH-1];
  assign out_data  = out_r;

endmodule

@@ src/fpc_checker.sv @@
module fpc_sva (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input fpc_pkg::fpc_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stage_reached == fpc_pkg::STG_MASKED |->
      !out_data.non_field && out_data.feature_value == 8'd0 &&
      out_data.reliability == 8'd0)
    else $error("masked beat carries stale fields");

  a_field_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.non_field |->
      out_data.stage_reached == fpc_pkg::STG_ALL ||
      out_data.stage_reached == fpc_pkg::STG_MASKED)
    else $error("field result without passing all tests");

  a_nonfield_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.non_field |->
      out_data.stage_reached != fpc_pkg::STG_ALL &&
      out_data.stage_reached != fpc_pkg::STG_MASKED)
    else $error("non-field result with passing stage code");

endmodule

bind field_pixel_classifier fpc_sva u_fpc_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/fpc_checker.sv @@
`timescale 1ns / 100ps

module fpc_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  fpc_pkg::fpc_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  fpc_pkg::fpc_out_t out_data,
  input  logic              cfg_we,
  input  logic [fpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]        cfg_wdata,
  output int                errors,
  output int                pending
);

  logic [7:0]        thr_regs [fpc_pkg::NUM_REGS];
  fpc_pkg::fpc_out_t expected_results [$];

  initial pending = 0;

  // two-sided scaling of v about threshold t over 0..255
  function automatic logic [7:0] scaled_dist(logic [7:0] v, logic [7:0] t);
    int unsigned span_lo, span_hi;
    span_lo = t;
    span_hi = 255 - t;
    if (v < t) begin
      if (v == 0 || span_lo == 0) return 8'd0;
      return 8'((int'(t - v) * 255) / span_lo);
    end
    if (v == 8'hFF) return 8'hFF;
    if (v > t) begin
      if (span_hi == 0) return 8'hFF;
      return 8'((int'(v - t) * 255) / span_hi);
    end
    if (span_lo > span_hi) return 8'(v / span_lo);
    if (span_hi == 0) return 8'd0;
    return 8'(v / span_hi);
  endfunction

  function automatic logic [7:0] clip_add(logic [7:0] a, logic [7:0] b);
    int s;
    s = a + b;
    return (s > 255) ? 8'hFF : 8'(s);
  endfunction

  function automatic logic near_peak(logic [7:0] v, logic [7:0] pk, logic [7:0] w);
    int d;
    d = (v >= pk) ? v - pk : pk - v;
    return d <= w;
  endfunction

  function automatic fpc_pkg::fpc_out_t classify(fpc_pkg::fpc_in_t px);
    fpc_pkg::fpc_out_t res;
    logic [7:0]        c;
    res = '{non_field: 1'b1, stage_reached: fpc_pkg::STG_NONE,
            feature_value: px.red_value, reliability: 8'd0};
    if (px.outside_mask) begin
      res = '{non_field: 1'b0, stage_reached: fpc_pkg::STG_MASKED,
              feature_value: 8'd0, reliability: 8'd0};
      return res;
    end
    res.reliability = scaled_dist(px.red_value, px.green_value);
    if (px.red_value < px.green_value) begin
      res.stage_reached = fpc_pkg::STG_CYAN;
      c = scaled_dist(px.blue_value, px.green_value);
      if (res.reliability > c) begin
        res.reliability = c; res.feature_value = px.blue_value;
      end
      if (px.blue_value < px.green_value) begin
        res.stage_reached = fpc_pkg::STG_GREEN;
        c = scaled_dist(px.green_value,
                        clip_add(thr_regs[fpc_pkg::REG_GREEN_PEAK],
                                 thr_regs[fpc_pkg::REG_GREEN_WIN]));
        if (res.reliability > c) begin
          res.reliability = c; res.feature_value = px.green_value;
        end
        if (near_peak(px.green_value, thr_regs[fpc_pkg::REG_GREEN_PEAK],
                      thr_regs[fpc_pkg::REG_GREEN_WIN])) begin
          res.stage_reached = fpc_pkg::STG_BLUE;
          c = scaled_dist(px.blue_value,
                          clip_add(thr_regs[fpc_pkg::REG_BLUE_PEAK],
                                   thr_regs[fpc_pkg::REG_BLUE_WIN]));
          if (res.reliability > c) begin
            res.reliability = c; res.feature_value = px.blue_value;
          end
          if (near_peak(px.blue_value, thr_regs[fpc_pkg::REG_BLUE_PEAK],
                        thr_regs[fpc_pkg::REG_BLUE_WIN])) begin
            res.stage_reached = fpc_pkg::STG_RED;
            c = scaled_dist(px.red_value,
                            clip_add(thr_regs[fpc_pkg::REG_RED_PEAK],
                                     thr_regs[fpc_pkg::REG_RED_WIN]));
            if (res.reliability > c) begin
              res.reliability = c; res.feature_value = px.red_value;
            end
            if (near_peak(px.red_value, thr_regs[fpc_pkg::REG_RED_PEAK],
                          thr_regs[fpc_pkg::REG_RED_WIN])) begin
              res.stage_reached = fpc_pkg::STG_GRAY;
              c = scaled_dist(px.gray_value,
                              clip_add(thr_regs[fpc_pkg::REG_GRAY_PEAK],
                                       thr_regs[fpc_pkg::REG_GRAY_WIN]));
              if (res.reliability > c) begin
                res.reliability = c; res.feature_value = px.gray_value;
              end
              if (near_peak(px.gray_value, thr_regs[fpc_pkg::REG_GRAY_PEAK],
                            thr_regs[fpc_pkg::REG_GRAY_WIN])) begin
                res.stage_reached = fpc_pkg::STG_ALL;
                res.non_field     = 1'b0;
              end
            end
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    fpc_pkg::fpc_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < fpc_pkg::NUM_REGS; i++) thr_regs[i] = 8'd0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.non_field !== want.non_field ||
              out_data.stage_reached !== want.stage_reached ||
              out_data.feature_value !== want.feature_value ||
              out_data.reliability !== want.reliability) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(classify(in_data));
      if (cfg_we) thr_regs[cfg_index] = cfg_wdata;
    end
    pending = expected_results.size();
  end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int NUM_RANDOM  = 1750;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fpc_pkg::fpc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fpc_pkg::fpc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [fpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  int errors;
  int pending;
  int idle_cycles = 0;
  logic [7:0] peaks [4];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  field_pixel_classifier dut (.*);

  fpc_checker checker_i (.*);

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[field_pixel_classifier] ERROR");
      $finish;
    end
  end

  // receiver: random stall before each beat
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      n = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  task automatic write_reg(logic [fpc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(fpc_pkg::fpc_in_t px, bit no_gap);
    int n;
    n = no_gap ? 0 : $urandom_range(0, 8);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk iff in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (fpc_pkg::PIPE_DEPTH + 2) @(posedge clk);
  endtask

  function automatic logic [7:0] near(logic [7:0] c, logic [7:0] w);
    int v;
    v = int'(c) + $urandom_range(0, 2 * w + 2) - int'(w) - 1;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // mostly pixels that walk the cascade; some pure noise
  function automatic fpc_pkg::fpc_in_t field_like(logic [7:0] w);
    fpc_pkg::fpc_in_t p;
    logic [63:0]      rnd;
    rnd = {$urandom, $urandom};
    p = rnd[$bits(fpc_pkg::fpc_in_t)-1:0];
    if ($urandom_range(0, 4) != 0) begin
      p.green_value = near(peaks[0], w);
      p.blue_value  = near(peaks[1], w);
      p.red_value   = near(peaks[2], w);
      p.gray_value  = near(peaks[3], w);
      p.outside_mask = ($urandom_range(0, 15) == 0);
    end
    return p;
  endfunction

  task automatic load_setting(logic [7:0] w);
    peaks[0] = 8'($urandom_range(60, 255));
    peaks[1] = 8'($urandom_range(0, peaks[0]));
    peaks[2] = 8'($urandom_range(0, peaks[0]));
    peaks[3] = 8'($urandom);
    write_reg(fpc_pkg::REG_GREEN_PEAK, peaks[0]);
    write_reg(fpc_pkg::REG_GREEN_WIN, w);
    write_reg(fpc_pkg::REG_BLUE_PEAK, peaks[1]);
    write_reg(fpc_pkg::REG_BLUE_WIN, w);
    write_reg(fpc_pkg::REG_RED_PEAK, peaks[2]);
    write_reg(fpc_pkg::REG_RED_WIN, w);
    write_reg(fpc_pkg::REG_GRAY_PEAK, peaks[3]);
    write_reg(fpc_pkg::REG_GRAY_WIN, w);
  endtask

  initial begin
    fpc_pkg::fpc_in_t px;
    logic [7:0] w;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed, registers at reset values
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 0);
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1);
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1);
    send_pixel('{8'd10, 8'd200, 8'd100, 8'd0, 1'b0}, 0);
    send_pixel('{8'd0, 8'd128, 8'd128, 8'd0, 1'b0}, 1);   // value equals threshold
    send_pixel('{8'd0, 8'd127, 8'd127, 8'd0, 1'b0}, 1);
    send_pixel('{8'd0, 8'd1, 8'd0, 8'd0, 1'b0}, 0);
    drain();

    // saturated thresholds, full windows: every window test passes
    peaks = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    for (int i = 0; i < fpc_pkg::NUM_REGS; i++) write_reg(i[fpc_pkg::CFG_IDX_W-1:0], 8'hFF);
    send_pixel('{8'd5, 8'd200, 8'd6, 8'd255, 1'b0}, 0);
    send_pixel('{8'd254, 8'd255, 8'd0, 8'd0, 1'b0}, 1);
    send_pixel('{8'd0, 8'd255, 8'd254, 8'd128, 1'b0}, 1);
    send_pixel('{8'd100, 8'd100, 8'd50, 8'd1, 1'b0}, 0);   // blue not below green
    drain();

    // one setting, one pixel per stage boundary
    write_reg(fpc_pkg::REG_GREEN_PEAK, 8'd150); write_reg(fpc_pkg::REG_GREEN_WIN, 8'd10);
    write_reg(fpc_pkg::REG_BLUE_PEAK, 8'd60);   write_reg(fpc_pkg::REG_BLUE_WIN, 8'd5);
    write_reg(fpc_pkg::REG_RED_PEAK, 8'd90);    write_reg(fpc_pkg::REG_RED_WIN, 8'd5);
    write_reg(fpc_pkg::REG_GRAY_PEAK, 8'd120);  write_reg(fpc_pkg::REG_GRAY_WIN, 8'd0);
    send_pixel('{8'd60, 8'd100, 8'd90, 8'd120, 1'b0}, 0);  // green fails
    send_pixel('{8'd20, 8'd150, 8'd90, 8'd120, 1'b0}, 1);  // blue fails
    send_pixel('{8'd60, 8'd150, 8'd20, 8'd120, 1'b0}, 1);  // red fails
    send_pixel('{8'd60, 8'd150, 8'd90, 8'd121, 1'b0}, 0);  // gray fails
    send_pixel('{8'd60, 8'd150, 8'd90, 8'd120, 1'b0}, 1);  // field
    send_pixel('{8'd60, 8'd150, 8'd90, 8'd120, 1'b1}, 1);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: w = 8'd0;
        1: w = 8'hFF;
        default: w = 8'($urandom_range(1, 40));
      endcase
      load_setting(w);
      for (int k = 0; k < NUM_RANDOM / 7; k++) begin
        px = field_like(w);
        send_pixel(px, ($urandom_range(0, 99) < 30) || (ph == 3));
      end
      drain();
    end

    if (errors == 0) begin
      $display("[field_pixel_classifier] OK");
    end else begin
      $display("[field_pixel_classifier] ERROR");
    end
    $finish;
  end
endmodule
